@@ hw/rtl/mactp_pkg.sv @@
// Package with constants, types and character helpers for the MAC address text parser.
`timescale 1ns / 1ps
`default_nettype none

package mactp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned MacW   = 48;
  localparam int unsigned CountW = 5;
  localparam int unsigned DigitW = 4;

  localparam logic [CountW-1:0] CountMax     = 5'd31;
  localparam logic [CountW-1:0] CompactLen   = 5'd12;
  localparam logic [CountW-1:0] SeparatedLen = 5'd17;
  localparam logic [CountW-1:0] FirstSepPos  = 5'd2;

  localparam logic [CharW-1:0] SepColon = 8'h3A;
  localparam logic [CharW-1:0] SepDash  = 8'h2D;

  typedef enum logic [1:0] {
    TrimLead = 2'd0,
    TrimBody = 2'd1,
    TrimTail = 2'd2
  } trim_phase_e;

  typedef struct packed {
    logic              is_hex;
    logic [DigitW-1:0] value;
  } hex_digit_t;

  function automatic logic is_blank(input logic [CharW-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic hex_digit_t hex_digit(input logic [CharW-1:0] c);
    hex_digit_t r;
    r.is_hex = 1'b0;
    r.value  = '0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      r.is_hex = 1'b1;
      r.value  = c[DigitW-1:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      r.is_hex = 1'b1;
      r.value  = DigitW'(c[2:0] + 3'd1) + 4'd8;
    end
    return r;
  endfunction

  function automatic logic is_sep_pos(input logic [CountW-1:0] p);
    return (p == 5'd2) || (p == 5'd5) || (p == 5'd8) || (p == 5'd11) || (p == 5'd14);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mac_address_text_parser.sv @@
// Top level of the MAC address text parser: character input stage, parse state and result register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one ASCII character per request, tlast on the final one, and returns one result per
// string: the 48-bit address with the first text digit most significant, plus an ok flag in
// tuser (the address reads zero when the flag is clear). Leading and trailing whitespace is
// skipped; accepted are 12 hex digits, or 17 characters with one ':' or '-' separator repeated
// at every third position. One character is accepted every cycle unless the input side is held;
// a result passes through one input register and then one result register. Only a
// stalled result with a further final character waiting holds the input side.
module mac_address_text_parser
  import mactp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [CharW-1:0] s_axis_tdata_i,   // [7:0] char_code
  input  wire logic             s_axis_tlast_i,   // last_char
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic [MacW-1:0]       m_axis_tdata_o,   // [47:0] mac_value
  output logic                  m_axis_tuser_o    // [0] mac_ok
);

  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;

  trim_phase_e       trim_q, trim_d;
  logic [CountW-1:0] count_q, count_d;
  logic              compact_ok_q, compact_ok_d;
  logic              sep_ok_q, sep_ok_d;
  logic [CharW-1:0]  sep_char_q, sep_char_d;
  logic [MacW-1:0]   acc_q, acc_d;

  logic            out_valid_q;
  logic [MacW-1:0] out_mac_q, out_mac_d;
  logic            out_ok_q, out_ok_d;

  logic       out_free;
  logic       step;
  logic       blank;
  hex_digit_t digit;
  logic       result_ok;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || step;

  assign blank = is_blank(in_char_q);
  assign digit = hex_digit(in_char_q);

  always_comb begin
    trim_d       = trim_q;
    count_d      = count_q;
    compact_ok_d = compact_ok_q;
    sep_ok_d     = sep_ok_q;
    sep_char_d   = sep_char_q;
    acc_d        = acc_q;
    if (blank) begin
      if (trim_q == TrimBody) begin
        trim_d = TrimTail;
      end
    end else begin
      if (trim_q == TrimTail) begin
        compact_ok_d = 1'b0;
        sep_ok_d     = 1'b0;
      end
      trim_d = TrimBody;
      if (!digit.is_hex) begin
        compact_ok_d = 1'b0;
      end else begin
        acc_d = {acc_q[MacW-DigitW-1:0], digit.value};
      end
      if (count_q < SeparatedLen) begin
        if (is_sep_pos(count_q)) begin
          if (count_q == FirstSepPos) begin
            if ((in_char_q != SepColon) && (in_char_q != SepDash)) begin
              sep_ok_d = 1'b0;
            end
            sep_char_d = in_char_q;
          end else if (in_char_q != sep_char_q) begin
            sep_ok_d = 1'b0;
          end
        end else if (!digit.is_hex) begin
          sep_ok_d = 1'b0;
        end
      end
      if (count_q < CountMax) begin
        count_d = count_q + 5'd1;
      end
    end
  end

  assign result_ok = ((count_d == CompactLen) && compact_ok_d) ||
                     ((count_d == SeparatedLen) && sep_ok_d);
  assign out_mac_d = result_ok ? acc_d : '0;
  assign out_ok_d  = result_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q       <= TrimLead;
      count_q      <= '0;
      compact_ok_q <= 1'b1;
      sep_ok_q     <= 1'b1;
      sep_char_q   <= '0;
      acc_q        <= '0;
    end else if (step) begin
      if (in_last_q) begin
        trim_q       <= TrimLead;
        count_q      <= '0;
        compact_ok_q <= 1'b1;
        sep_ok_q     <= 1'b1;
        sep_char_q   <= '0;
        acc_q        <= '0;
      end else begin
        trim_q       <= trim_d;
        count_q      <= count_d;
        compact_ok_q <= compact_ok_d;
        sep_ok_q     <= sep_ok_d;
        sep_char_q   <= sep_char_d;
        acc_q        <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_mac_q <= out_mac_d;
      out_ok_q  <= out_ok_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_mac_q;
  assign m_axis_tuser_o  = out_ok_q;

`ifndef ASSERT_OFF
  a_bad_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("rejected address carries nonzero data");

  a_empty_is_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> trim_q == TrimLead)
    else $error("trim phase left lead with no content counted");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_last_q |=> count_q == '0 && trim_q == TrimLead && compact_ok_q && sep_ok_q)
    else $error("parse state not cleared after final character");

  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_char_q) && $stable(in_last_q))
    else $error("held input character changed");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !(step && in_last_q))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ tb/mac_address_text_parser_checker.sv @@
// Checker for the MAC address text parser: predicts each result from the requests and compares.
`timescale 1ns / 1ps

module mac_address_text_parser_checker
  import mactp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  input  wire logic             s_tready_i,
  input  wire logic [CharW-1:0] s_tdata_i,
  input  wire logic             s_tlast_i,
  input  wire logic             m_tvalid_i,
  input  wire logic             m_tready_i,
  input  wire logic [MacW-1:0]  m_tdata_i,
  input  wire logic             m_tuser_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    good_addrs_o
);

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;

  typedef struct packed {
    logic [MacW-1:0] mac;
    logic            ok;
  } mac_result_t;

  mac_result_t       addr_expect_q[$];
  trim_phase_e       phase;
  logic [CountW-1:0] n_content;
  logic              compact_ok;
  logic              sep_ok;
  logic [CharW-1:0]  sep_char;
  logic [MacW-1:0]   nibbles;
  int                mismatches;
  int                results;
  int                good_addrs;

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  // 16 marks a character that is no hex digit
  function automatic logic [4:0] hex_value(input logic [CharW-1:0] c);
    if ((c >= ChZero) && (c <= ChNine)) return 5'(c - ChZero);
    if ((c >= ChLowA) && (c <= ChLowF)) return 5'(c - ChLowA) + 5'd10;
    if ((c >= ChUpA) && (c <= ChUpF)) return 5'(c - ChUpA) + 5'd10;
    return 5'd16;
  endfunction

  task automatic clear_parse();
    phase      = TrimLead;
    n_content  = '0;
    compact_ok = 1'b1;
    sep_ok     = 1'b1;
    sep_char   = '0;
    nibbles    = '0;
  endtask

  task automatic take_char(input logic [CharW-1:0] c, input logic last);
    logic [4:0]        d;
    logic [CountW-1:0] pos;
    mac_result_t       r;
    if (is_space(c)) begin
      if (phase == TrimBody) phase = TrimTail;
    end else begin
      if (phase == TrimTail) begin
        compact_ok = 1'b0;
        sep_ok     = 1'b0;
      end
      phase = TrimBody;
      pos   = n_content;
      d     = hex_value(c);
      if (d[4]) begin
        compact_ok = 1'b0;
      end else begin
        nibbles = {nibbles[MacW-5:0], d[3:0]};
      end
      if (pos < SeparatedLen) begin
        if ((pos == 5'd2) || (pos == 5'd5) || (pos == 5'd8) || (pos == 5'd11) ||
            (pos == 5'd14)) begin
          if (pos == FirstSepPos) begin
            if ((c != SepColon) && (c != SepDash)) sep_ok = 1'b0;
            sep_char = c;
          end else if (c != sep_char) begin
            sep_ok = 1'b0;
          end
        end else if (d[4]) begin
          sep_ok = 1'b0;
        end
      end
      if (n_content != CountMax) n_content = n_content + 5'd1;
    end
    if (last) begin
      r.ok  = ((n_content == CompactLen) && compact_ok) ||
              ((n_content == SeparatedLen) && sep_ok);
      r.mac = r.ok ? nibbles : '0;
      addr_expect_q.push_back(r);
      clear_parse();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    mac_result_t want;
    if (!rst_ni) begin
      clear_parse();
      addr_expect_q.delete();
      mismatches = 0;
      results    = 0;
      good_addrs = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        results = results + 1;
        if (addr_expect_q.size() == 0) begin
          $error("mac result: none expected, got mac_value %h mac_ok %b", m_tdata_i, m_tuser_i);
          mismatches = mismatches + 1;
        end else begin
          want = addr_expect_q.pop_front();
          if (want.ok) good_addrs = good_addrs + 1;
          if (m_tdata_i !== want.mac) begin
            $error("mac_value: expected %h, got %h", want.mac, m_tdata_i);
            mismatches = mismatches + 1;
          end
          if (m_tuser_i !== want.ok) begin
            $error("mac_ok: expected %b, got %b", want.ok, m_tuser_i);
            mismatches = mismatches + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) take_char(s_tdata_i, s_tlast_i);
    end
    mismatches_o <= mismatches;
    pending_o    <= addr_expect_q.size();
    results_o    <= results;
    good_addrs_o <= good_addrs;
  end

endmodule

@@ tb/mac_address_text_parser_tb.sv @@
// Testbench top for the MAC address text parser: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps

module mac_address_text_parser_tb;
  import mactp_pkg::*;

  localparam int ItemsTarget = 1900;
  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 8;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;

  logic             clk      = 1'b0;
  logic             rst_n    = 1'b0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [CharW-1:0] s_tdata  = '0;
  logic             s_tlast  = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [MacW-1:0]  m_tdata;
  logic             m_tuser;

  int mismatches;
  int pending;
  int results;
  int good_addrs;
  int cycles     = 0;
  int stall_left = 0;
  int chars_sent = 0;
  int n_strings  = 0;
  bit calm       = 1'b0;

  logic [CharW-1:0] text_q[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mac_address_text_parser u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  mac_address_text_parser_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .good_addrs_o (good_addrs)
  );

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int gap_len();
    if (calm || ($urandom_range(0, 99) < 60)) return 0;
    return stall_len();
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("mac_address_text_parser_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && ($urandom_range(0, 3) == 0)) begin
      m_tready   <= 1'b0;
      stall_left <= stall_len() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [CharW-1:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return ChZero + CharW'(v);
    return ($urandom_range(0, 1) ? ChUpA : ChLowA) + CharW'(v - 10);
  endfunction

  function automatic logic [CharW-1:0] rand_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? ChSpace : ChTab + CharW'(k);
  endfunction

  task automatic add_blanks(input int n);
    for (int i = 0; i < n; i++) text_q.push_back(rand_blank());
  endtask

  task automatic build_address(input bit separated);
    logic [CharW-1:0] sep;
    text_q.delete();
    sep = $urandom_range(0, 1) ? SepColon : SepDash;
    if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 3));
    for (int i = 0; i < (separated ? 17 : 12); i++) begin
      if (separated && (i % 3 == 2)) text_q.push_back(sep);
      else text_q.push_back(rand_hex());
    end
    if ($urandom_range(0, 2) == 0) add_blanks($urandom_range(1, 3));
  endtask

  task automatic corrupt_text();
    int i;
    i = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 3))
      0: text_q[i] = CharW'($urandom_range(0, 255));
      1: text_q.insert($urandom_range(1, text_q.size() - 1), rand_blank());
      2: text_q.delete(i);
      default: begin
        if (text_q[i] == SepColon) text_q[i] = SepDash;
        else if (text_q[i] == SepDash) text_q[i] = SepColon;
        else text_q.push_back(rand_hex());
      end
    endcase
  endtask

  task automatic send_char(input logic [CharW-1:0] c, input logic last);
    int g;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
    g = gap_len();
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    n_strings++;
  endtask

  task automatic load_str(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_str(" \t");
    send_text();
    load_str("a b");
    send_text();
    load_str("00.");
    send_text();
    text_q = '{8'hFF};
    send_text();
    text_q = '{8'h00};
    send_text();
    load_str(" 0123456789aF");
    text_q.push_back(ChCr);
    send_text();
    drain_results();

    while (chars_sent < ItemsTarget) begin
      calm = (n_strings % 16) < 3;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        build_address(1'b0);
      end else if (kind < 65) begin
        build_address(1'b1);
      end else if (kind < 82) begin
        build_address($urandom_range(0, 1));
        corrupt_text();
      end else if (kind < 87) begin
        text_q.delete();
        repeat ($urandom_range(28, 45)) text_q.push_back(rand_hex());
      end else if (kind < 95) begin
        text_q.delete();
        repeat ($urandom_range(1, 20)) text_q.push_back(CharW'($urandom_range(0, 255)));
      end else begin
        text_q.delete();
        add_blanks($urandom_range(1, 4));
      end
      send_text();
      if (n_strings % 25 == 24) drain_results();
    end

    calm = 1'b0;
    drain_results();
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d characters in %0d strings, both address forms, bad text and noise",
             chars_sent, n_strings);
    $display("checked %0d results, %0d of them well-formed addresses", results, good_addrs);
    if (mismatches == 0) begin
      $display("mac_address_text_parser_tb: done, clean");
    end else begin
      $display("mac_address_text_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
